/* hw/rtl/mlfq_pkg.sv */
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types, field widths and codes of the multilevel feedback queue
// scheduler: request and result payloads, controller commands and status.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  // Default sizes, handed down from the top level
  localparam int NUM_LEVELS_DEF  = 6;
  localparam int MAX_THREADS_DEF = 64;
  localparam int LEVEL_DEPTH_DEF = 16;

  // Fixed field widths
  localparam int ID_W       = 6;
  localparam int LVL_W      = 3;
  localparam int OCC_W      = 5;
  localparam int SLICE_W    = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SLICE     = 1'b1;

  // Register reset values
  localparam logic [LVL_W-1:0]   MAX_LEVEL_RESET = 3'd5;
  localparam logic [SLICE_W-1:0] SLICE_RESET     = 8'd3;

  typedef enum logic {
    OP_ENQUEUE  = 1'b0,
    OP_DISPATCH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_ENQUEUED   = 2'd0,
    ST_DISPATCHED = 2'd1,
    ST_IDLE       = 2'd2,
    ST_DROPPED    = 2'd3
  } status_t;

  typedef struct packed {
    op_t             operation;
    logic [ID_W-1:0] thread_id;
    logic            was_preempted;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    chosen_thread;
    logic [LVL_W-1:0]   chosen_level;
    logic [OCC_W-1:0]   level_occupancy;
    logic [SLICE_W-1:0] granted_slice;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;   // write one cleared thread table entry
    logic take;    // latch the request, read from the input item
    logic commit;  // write back state and load the result register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;  // clearing pass is at its last entry
  } dp_stat_t;

endpackage

/* hw/rtl/mlfq_if.sv */
// ----------------------------------------------------------------------------
// mlfq_req_if / mlfq_rsp_if
// Valid/ready channels carrying scheduler requests and scheduler results.
// ----------------------------------------------------------------------------
interface mlfq_req_if import mlfq_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mlfq_rsp_if import mlfq_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/multilevel_feedback_queue_scheduler_core.sv */
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler_core
// Multilevel feedback queue scheduler: enqueue threads into priority levels
// with demotion on preemption (back to level 0 from the lowest level), dispatch the head of the best non-empty level.
//
//   channel  dir  handshake          payload
//   req      in   req.valid/ready    operation, thread_id, was_preempted
//   rsp      out  rsp.valid/ready    status, chosen_thread, chosen_level,
//                                    level_occupancy, granted_slice
//   cfg      in   cfg_we             cfg_index, cfg_data
//
// Each item has its thread table entry and the queue store head read when
// it is accepted, then the table and store written and the result loaded.
// After reset a clearing pass walks the thread table, MAX_THREADS entries
// (64 by default); no item is accepted during it, cfg writes are.
// A result not yet taken holds the next item in its write-back cycle.
// ----------------------------------------------------------------------------
module multilevel_feedback_queue_scheduler_core import mlfq_pkg::*; #(
  parameter int NUM_LEVELS  = NUM_LEVELS_DEF,
  parameter int MAX_THREADS = MAX_THREADS_DEF,
  parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  mlfq_req_if.sink              req,
  mlfq_rsp_if.source            rsp
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     req_ready;
  logic     rsp_valid;
  rsp_t     rsp_data;

  assign req.ready = req_ready;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  mlfq_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mlfq_dp #(
    .NUM_LEVELS  (NUM_LEVELS),
    .MAX_THREADS (MAX_THREADS),
    .LEVEL_DEPTH (LEVEL_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_data  (req.data),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_data  (rsp_data)
  );

endmodule

/* hw/rtl/mlfq_ram.sv */
// ----------------------------------------------------------------------------
// mlfq_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. A read of an address written at the same edge returns
// the old data.
// ----------------------------------------------------------------------------
module mlfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/mlfq_dp.sv */
// ----------------------------------------------------------------------------
// mlfq_dp
// Scheduler datapath: configuration registers, thread level table, level
// queue store, per-level head/tail/count registers and the result register.
// ----------------------------------------------------------------------------
module mlfq_dp import mlfq_pkg::*; #(
  parameter int NUM_LEVELS  = NUM_LEVELS_DEF,
  parameter int MAX_THREADS = MAX_THREADS_DEF,
  parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  req_t                  req_data,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output rsp_t                  rsp_data
);

  localparam int LIX_W = $clog2(NUM_LEVELS);
  localparam int TW    = $clog2(MAX_THREADS);
  localparam int PW    = $clog2(LEVEL_DEPTH);
  localparam int CW    = $clog2(LEVEL_DEPTH + 1);
  localparam int FD    = NUM_LEVELS * LEVEL_DEPTH;
  localparam int AW    = $clog2(FD);
  localparam int RW    = ID_W + TW;
  localparam int TE_W  = LIX_W + 1;

  // Reduce a thread id modulo the table size, one restoring step per bit
  function automatic logic [ID_W-1:0] reduce_id(input logic [ID_W-1:0] id);
    logic [RW-1:0] v;
    v = RW'(id);
    for (int k = ID_W - 1; k >= 0; k--) begin
      if (v >= (RW'(MAX_THREADS) << k)) begin
        v = v - (RW'(MAX_THREADS) << k);
      end
    end
    return v[ID_W-1:0];
  endfunction

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    return (p == PW'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] slot_addr(input logic [LIX_W-1:0] lv,
                                               input logic [PW-1:0]    p);
    return AW'(LEVEL_DEPTH) * AW'(lv) + AW'(p);
  endfunction

  // Configuration registers
  logic [LVL_W-1:0]   max_level;
  logic [SLICE_W-1:0] slice_length;

  // Latched request
  op_t             op_q;
  logic [ID_W-1:0] tid_q;
  logic            pre_q;

  // Queue pointers
  logic [PW-1:0] head  [NUM_LEVELS];
  logic [PW-1:0] tail  [NUM_LEVELS];
  logic [CW-1:0] count [NUM_LEVELS];

  // Clearing pass counter
  logic [TW-1:0] clr_cnt;

  // Thread table ports
  logic            tt_we;
  logic [TW-1:0]   tt_waddr;
  logic [TE_W-1:0] tt_wdata;
  logic [TW-1:0]   tt_raddr;
  logic [TE_W-1:0] tt_rdata;

  // Queue store ports
  logic            qs_we;
  logic [AW-1:0]   qs_waddr;
  logic [AW-1:0]   qs_raddr;
  logic [ID_W-1:0] qs_rdata;

  logic             any_ready;
  logic [LIX_W-1:0] sel;
  logic [LIX_W-1:0] lowest;
  logic [LIX_W-1:0] lv_old;
  logic             known;
  logic [LIX_W-1:0] lv_enq;
  logic [CW-1:0]    occ_enq;
  logic             full;
  rsp_t             rsp_next;

  // Update configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_level    <= MAX_LEVEL_RESET;
      slice_length <= SLICE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_MAX_LEVEL) begin
        max_level <= cfg_data[LVL_W-1:0];
      end else if (cfg_index == REG_SLICE) begin
        slice_length <= cfg_data[SLICE_W-1:0];
      end
    end
  end

  // Latch the accepted request
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_q  <= req_data.operation;
      tid_q <= reduce_id(req_data.thread_id);
      pre_q <= req_data.was_preempted;
    end
  end

  // Advance the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign stat.clear_last = (clr_cnt == TW'(MAX_THREADS - 1));

  // Pick the highest-priority non-empty level
  always_comb begin
    sel       = '0;
    any_ready = 1'b0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (count[i] != '0) begin
        sel       = LIX_W'(i);
        any_ready = 1'b1;
      end
    end
  end

  // Work out the level of an enqueued thread
  always_comb begin
    lowest = (max_level > LVL_W'(NUM_LEVELS - 1)) ? LIX_W'(NUM_LEVELS - 1)
                                                  : max_level[LIX_W-1:0];
    known  = tt_rdata[LIX_W];
    lv_old = tt_rdata[LIX_W-1:0];
    if (!known) begin
      lv_enq = '0;
    end else if (pre_q) begin
      lv_enq = (lv_old < lowest) ? lv_old + 1'b1 : '0;
    end else begin
      lv_enq = lv_old;
    end
    occ_enq = count[lv_enq];
    full    = (occ_enq >= CW'(LEVEL_DEPTH));
  end

  // Drive the thread table: clearing pass or write-back of the entry
  always_comb begin
    tt_we    = cmd.clear || (cmd.commit && op_q == OP_ENQUEUE);
    tt_waddr = cmd.clear ? clr_cnt : TW'(tid_q);
    tt_wdata = cmd.clear ? '0 : {1'b1, lv_enq};
    tt_raddr = cmd.take ? TW'(reduce_id(req_data.thread_id)) : TW'(tid_q);
  end

  // Drive the queue store: push at the tail, read at the head
  always_comb begin
    qs_we    = cmd.commit && op_q == OP_ENQUEUE && !full;
    qs_waddr = slot_addr(lv_enq, tail[lv_enq]);
    qs_raddr = slot_addr(sel, head[sel]);
  end

  mlfq_ram #(
    .WIDTH (TE_W),
    .DEPTH (MAX_THREADS)
  ) u_thread_table (
    .clk   (clk),
    .we    (tt_we),
    .waddr (tt_waddr),
    .wdata (tt_wdata),
    .raddr (tt_raddr),
    .rdata (tt_rdata)
  );

  mlfq_ram #(
    .WIDTH (ID_W),
    .DEPTH (FD)
  ) u_queue_store (
    .clk   (clk),
    .we    (qs_we),
    .waddr (qs_waddr),
    .wdata (tid_q),
    .raddr (qs_raddr),
    .rdata (qs_rdata)
  );

  // Update queue pointers and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
    end else if (cmd.commit) begin
      if (op_q == OP_DISPATCH) begin
        if (any_ready) begin
          head[sel]  <= next_ptr(head[sel]);
          count[sel] <= count[sel] - 1'b1;
        end
      end else if (!full) begin
        tail[lv_enq]  <= next_ptr(tail[lv_enq]);
        count[lv_enq] <= occ_enq + 1'b1;
      end
    end
  end

  // Build the result
  always_comb begin
    if (op_q == OP_DISPATCH) begin
      if (any_ready) begin
        rsp_next.status          = ST_DISPATCHED;
        rsp_next.chosen_thread   = qs_rdata;
        rsp_next.chosen_level    = LVL_W'(sel);
        rsp_next.level_occupancy = OCC_W'(count[sel]);
        rsp_next.granted_slice   = slice_length;
      end else begin
        rsp_next.status          = ST_IDLE;
        rsp_next.chosen_thread   = '0;
        rsp_next.chosen_level    = '0;
        rsp_next.level_occupancy = '0;
        rsp_next.granted_slice   = '0;
      end
    end else begin
      rsp_next.status          = full ? ST_DROPPED : ST_ENQUEUED;
      rsp_next.chosen_thread   = '0;
      rsp_next.chosen_level    = LVL_W'(lv_enq);
      rsp_next.level_occupancy = OCC_W'(occ_enq);
      rsp_next.granted_slice   = '0;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp_data <= rsp_next;
    end
  end

endmodule

/* hw/rtl/mlfq_ctl.sv */
// ----------------------------------------------------------------------------
// mlfq_ctl
// Scheduler controller: clearing pass after reset, accept of one item,
// commit once the result register is free, and the result valid flag.
// ----------------------------------------------------------------------------
module mlfq_ctl import mlfq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR  = 3'b001,
    S_READY  = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // Decode commands
  always_comb begin
    req_ready  = (state == S_READY);
    cmd.clear  = (state == S_CLEAR);
    cmd.take   = (state == S_READY) && req_valid;
    cmd.commit = (state == S_FINISH) && (!rsp_valid || rsp_ready);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (stat.clear_last) state_next = S_READY;
      end
      S_READY: begin
        if (req_valid) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (cmd.commit) state_next = S_READY;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Hold the result valid until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("second item accepted before commit");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> rsp_valid)
    else $error("committed result not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |-> !cmd.commit)
    else $error("result register overwritten while held");

  a_clear_exit: assert property (@(posedge clk) disable iff (rst)
    (cmd.clear && stat.clear_last) |=> req_ready)
    else $error("clearing pass did not end");

endmodule
